// ===== rtl/core/bra_pkg.sv =====
// Shared package for the bitmap run allocator: command codes, word geometry,
// controller/datapath interface structs and the per-word run search functions.
// No dependencies.
`default_nettype none

package bra_pkg;

  // Geometry of one map word and widths of the item fields.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LEN_W     = 11;

  // Command codes carried in the input transfer.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item, reset pointer, carry and result
    logic rd_scan;    // read the word at the scan pointer
    logic rd_idx;     // read the word that holds bit_index
    logic addr_inc;   // advance the word pointer
    logic wr_clear;   // write zeros at the word pointer
    logic wr_bit;     // write back the read word with one bit replaced
    logic eval_scan;  // evaluate the read word for a free run
    logic eval_test;  // capture the tested bit
  } bra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             len_ok;
    logic             idx_ok;
    logic             addr_last;
    logic             eval_last;
    logic             hit;
  } bra_stat_t;

  // For every bit position of a word, whether a free run of the wanted length
  // ends there. A run either continues from the previous words (need is the
  // number of free bits still wanted) or lies wholly inside this word.
  function automatic word_t run_hits(word_t used, logic [LEN_W-1:0] want,
                                     logic [LEN_W-1:0] need);
    word_t          hits;
    word_t          low_mask;
    word_t          ones_w;
    word_t          win;
    logic           carry_ok;
    logic           word_ok;
    logic [BIT_W:0] amt;
    hits = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      low_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - p);
      carry_ok = ((used & low_mask) == '0) && (need <= LEN_W'(p + 1));
      word_ok  = 1'b0;
      if (want <= LEN_W'(p + 1)) begin
        amt     = (BIT_W + 1)'(WORD_BITS) - want[BIT_W:0];
        ones_w  = {WORD_BITS{1'b1}} >> amt;
        win     = ones_w << ((BIT_W + 1)'(p + 1) - want[BIT_W:0]);
        word_ok = ((used & win) == '0);
      end
      hits[p] = carry_ok || word_ok;
    end
    return hits;
  endfunction

  // Position of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] first_set(word_t v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (v[p]) begin
        pos = BIT_W'(p);
      end
    end
    return pos;
  endfunction

  // Number of free bits at the top end of a word.
  function automatic logic [BIT_W:0] top_free(word_t used);
    logic [BIT_W:0] cnt;
    cnt = (BIT_W + 1)'(WORD_BITS);
    for (int p = 0; p < WORD_BITS; p++) begin
      if (used[p]) begin
        cnt = (BIT_W + 1)'(WORD_BITS - 1 - p);
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bra_datapath.sv =====
// Datapath of the bitmap run allocator: the occupancy memory, the word
// pointer, the run carry and the result registers.
// Depends on bra_pkg.
`default_nettype none

module bra_datapath import bra_pkg::*; #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [IDX_W-1:0]    bit_index_i,
  input  wire logic                bit_value_i,
  input  wire logic [LEN_W-1:0]    run_length_i,
  input  wire bra_cmd_t            ctrl_i,
  output bra_stat_t                stat_o,
  output logic                     found_o,
  output logic [IDX_W-1:0]         run_start_o,
  output logic                     bit_state_o
);

  localparam int unsigned NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned LAST_BITS = MAP_BITS - (NUM_WORDS - 1) * WORD_BITS;
  localparam int unsigned POS_W     = WA_W + BIT_W;
  localparam int unsigned SUM_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam word_t PAD_MASK = ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
  localparam logic [WA_W-1:0] LAST_ADDR = WA_W'(NUM_WORDS - 1);

  // Captured input item.
  logic [CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic             val_q;
  logic [LEN_W-1:0] len_q;

  // Pointer, memory read data and scan state.
  logic [WA_W-1:0]  addr_d, addr_q;
  logic [WA_W-1:0]  eval_q;
  word_t            rdata_q;
  logic [LEN_W-1:0] carry_d, carry_q;

  // Result registers.
  logic             found_q;
  logic [IDX_W-1:0] start_q;
  logic             state_q;

  word_t            map_mem [NUM_WORDS];

  logic [WA_W-1:0]  idx_word;
  logic [BIT_W-1:0] idx_bit;
  logic [WA_W-1:0]  rd_addr;
  logic [WA_W-1:0]  wr_addr;
  word_t            wr_data;
  word_t            merged;
  logic             wr_en;
  logic             rd_en;
  logic             eval_last;
  word_t            used;
  logic [LEN_W-1:0] need;
  word_t            hits;
  logic             hit;
  logic [BIT_W-1:0] hit_pos;
  logic [SUM_W-1:0] start_sum;

  // Address decode for bit commands.
  assign idx_word = WA_W'(32'(idx_q) >> BIT_W);
  assign idx_bit  = idx_q[BIT_W-1:0];

  // Memory port selection.
  assign rd_en   = ctrl_i.rd_scan || ctrl_i.rd_idx;
  assign rd_addr = ctrl_i.rd_scan ? addr_q : idx_word;
  assign wr_en   = ctrl_i.wr_clear || ctrl_i.wr_bit;
  assign wr_addr = ctrl_i.wr_clear ? addr_q : idx_word;

  always_comb begin
    merged          = rdata_q;
    merged[idx_bit] = val_q;
  end

  assign wr_data = ctrl_i.wr_clear ? '0 : merged;

  // Occupancy memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
      eval_q  <= rd_addr;
    end
  end

  // Word evaluation: bits past the end of the map count as used.
  assign eval_last = (eval_q == LAST_ADDR);
  assign used      = rdata_q | (eval_last ? PAD_MASK : '0);
  assign need      = len_q - carry_q;
  assign hits      = run_hits(used, len_q, need);
  assign hit       = |hits;
  assign hit_pos   = first_set(hits);
  assign start_sum = SUM_W'({eval_q, hit_pos}) + SUM_W'(1) - SUM_W'(len_q);

  // Free bits carried into the next word.
  always_comb begin
    if (used == '0) begin
      carry_d = carry_q + LEN_W'(WORD_BITS);
    end else begin
      carry_d = LEN_W'(top_free(used));
    end
  end

  // Word pointer.
  always_comb begin
    addr_d = addr_q;
    if (ctrl_i.load) begin
      addr_d = '0;
    end else if (ctrl_i.addr_inc) begin
      addr_d = addr_q + WA_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  // Item capture, run carry and results.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      idx_q   <= bit_index_i;
      val_q   <= bit_value_i;
      len_q   <= run_length_i;
      carry_q <= '0;
      found_q <= 1'b0;
      start_q <= '0;
      state_q <= 1'b0;
    end else begin
      if (ctrl_i.eval_scan) begin
        carry_q <= carry_d;
        if (hit) begin
          found_q <= 1'b1;
          start_q <= start_sum[IDX_W-1:0];
        end
      end
      if (ctrl_i.eval_test) begin
        state_q <= rdata_q[idx_bit];
      end
    end
  end

  // Status towards the controller.
  assign stat_o.cmd       = cmd_q;
  assign stat_o.len_ok    = (len_q != '0) && (32'(len_q) <= MAP_BITS);
  assign stat_o.idx_ok    = (32'(idx_q) < MAP_BITS);
  assign stat_o.addr_last = (addr_q == LAST_ADDR);
  assign stat_o.eval_last = eval_last;
  assign stat_o.hit       = hit;

  assign found_o     = found_q;
  assign run_start_o = start_q;
  assign bit_state_o = state_q;

endmodule

`default_nettype wire

// ===== rtl/core/bra_ctrl.sv =====
// Controller of the bitmap run allocator: sequences the clearing pass, the
// word-by-word scan, the bit test and the read-modify-write of single bits.
// Depends on bra_pkg.
`default_nettype none

module bra_ctrl import bra_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_free_i,
  output logic           push_o,
  input  wire bra_stat_t stat_i,
  output bra_cmd_t       ctrl_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_TEST   = 3'd5;
  localparam logic [2:0] ST_WRITE  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_d, state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    push_o  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        ctrl_o.wr_clear = 1'b1;
        ctrl_o.addr_inc = 1'b1;
        if (stat_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.cmd)
          CMD_CLEAR: begin
            state_d = ST_SWEEP;
          end
          CMD_SCAN: begin
            if (stat_i.len_ok) begin
              ctrl_o.rd_scan  = 1'b1;
              ctrl_o.addr_inc = 1'b1;
              state_d         = ST_SCAN;
            end else begin
              state_d = ST_FINISH;
            end
          end
          CMD_TEST: begin
            if (stat_i.idx_ok) begin
              ctrl_o.rd_idx = 1'b1;
              state_d       = ST_TEST;
            end else begin
              state_d = ST_FINISH;
            end
          end
          default: begin
            if (stat_i.idx_ok) begin
              ctrl_o.rd_idx = 1'b1;
              state_d       = ST_WRITE;
            end else begin
              state_d = ST_FINISH;
            end
          end
        endcase
      end
      ST_SWEEP: begin
        ctrl_o.wr_clear = 1'b1;
        ctrl_o.addr_inc = 1'b1;
        if (stat_i.addr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        ctrl_o.eval_scan = 1'b1;
        if (stat_i.hit || stat_i.eval_last) begin
          state_d = ST_FINISH;
        end else begin
          ctrl_o.rd_scan  = 1'b1;
          ctrl_o.addr_inc = 1'b1;
        end
      end
      ST_TEST: begin
        ctrl_o.eval_test = 1'b1;
        state_d          = ST_FINISH;
      end
      ST_WRITE: begin
        ctrl_o.wr_bit = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // The memory has one write port.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.wr_clear && ctrl_o.wr_bit))
    else $error("clear and bit write issued together");

  // The memory has one read port.
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.rd_scan && ctrl_o.rd_idx))
    else $error("scan and index read issued together");

  // A found run ends the scan at once.
  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && stat_i.hit) |=> (state_q == ST_FINISH))
    else $error("scan went on after a hit");

  // Each result handed out returns the controller to idle.
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (in_ready_o && !$past(in_ready_o)))
    else $error("controller not idle after a result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_run_allocator.sv =====
// Bitmap run allocator: first-fit search for free runs in an occupancy map.
// Top level with stream ports and output register; depends on bra_pkg,
// bra_ctrl and bra_datapath.
//
// Usage:
//   One command arrives per input transfer on the s_axis group and yields
//   exactly one result transfer on the m_axis group. Commands are clear-all,
//   scan for a free run of run_length bits (lowest start wins), test one bit
//   and write one bit. Bits at or above MAP_BITS are never reported or
//   changed; a zero or over-long run_length reports not found.
//   The map is held as ceil(MAP_BITS/32) words of 32 bits in a single-port
//   memory, one word read or written per cycle: test reads one word, write
//   reads and writes back one word, clear-all writes every word and scan
//   reads word by word, ending early on a hit.
//   One command in work at a time; tready only when idle.
//   The result sits in an output register, so the next command is taken while
//   a result still waits; a new result waits until that register is free.
//   After reset a clearing pass frees the whole map; s_axis_tready stays low
//   until it ends.
`default_nettype none

module bitmap_run_allocator import bra_pkg::*; #(
  parameter int unsigned MAP_BITS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] cmd, [11:2] bit_index, [12] bit_value, [23:13] run_length
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] found, [10:1] run_start, [11] bit_state, [15:12] zero
  output logic [15:0]      m_axis_tdata
);

  bra_cmd_t         ctrl;
  bra_stat_t        stat;
  logic             push;
  logic             out_free;
  logic             found;
  logic [IDX_W-1:0] run_start;
  logic             bit_state;

  logic             m_valid_d, m_valid_q;
  logic [11:0]      m_data_q;

  bra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .push_o     (push),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  bra_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (s_axis_tdata[1:0]),
    .bit_index_i  (s_axis_tdata[11:2]),
    .bit_value_i  (s_axis_tdata[12]),
    .run_length_i (s_axis_tdata[23:13]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .found_o      (found),
    .run_start_o  (run_start),
    .bit_state_o  (bit_state)
  );

  // Output register: free when empty or when its transfer completes now.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (push) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_data_q <= {bit_state, run_start, found};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

endmodule

`default_nettype wire
